// ----- src/i2a_pkg.sv -----
package i2a_pkg;

  localparam int ValueWidth    = 32;
  localparam int CharWidth     = 8;
  localparam int CountWidth    = 31;
  localparam int DigitWidth    = 4;
  localparam int StackDepth    = 10;
  localparam int StackIdxWidth = $clog2(StackDepth + 1);
  localparam int StepWidth     = 3;

  localparam logic [ValueWidth-1:0] RecipTen = 32'hCCCC_CCCD;
  localparam int RecipShift = 35;
  localparam int QuotWidth  = 2 * ValueWidth - RecipShift;

  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  typedef enum logic [1:0] {
    OP_SDEC,
    OP_UDEC,
    OP_LHEX,
    OP_UHEX
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_MUL,
    ACT_DEC,
    ACT_HEX,
    ACT_SIGN,
    ACT_POP
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_HEX,
    COND_QNZ,
    COND_VNZ,
    COND_MORE
  } cond_t;

  typedef struct packed {
    act_t                 act;
    cond_t                cond;
    logic [StepWidth-1:0] jmp;
    logic [StepWidth-1:0] nxt;
  } uword_t;

  typedef struct packed {
    act_t act;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic neg;
    logic hex;
    logic q_nz;
    logic v_nz;
    logic more;
  } stat_t;

endpackage

// ----- src/i2a_seq.sv -----
module i2a_seq
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  localparam logic [StepWidth-1:0] StepLoad = 3'd0;
  localparam logic [StepWidth-1:0] StepDisp = 3'd1;
  localparam logic [StepWidth-1:0] StepMul  = 3'd2;
  localparam logic [StepWidth-1:0] StepDec  = 3'd3;
  localparam logic [StepWidth-1:0] StepHex  = 3'd4;
  localparam logic [StepWidth-1:0] StepSign = 3'd5;
  localparam logic [StepWidth-1:0] StepPop  = 3'd6;
  localparam logic [StepWidth-1:0] StepSpare = 3'd7;

  function automatic uword_t ucode(input logic [StepWidth-1:0] s);
    uword_t w;
    unique case (s)
      StepLoad:  w = '{ACT_LOAD, COND_ALWAYS, StepDisp, StepDisp};
      StepDisp:  w = '{ACT_NONE, COND_HEX,    StepHex,  StepMul};
      StepMul:   w = '{ACT_MUL,  COND_ALWAYS, StepDec,  StepDec};
      StepDec:   w = '{ACT_DEC,  COND_QNZ,    StepMul,  StepSign};
      StepHex:   w = '{ACT_HEX,  COND_VNZ,    StepHex,  StepSign};
      StepSign:  w = '{ACT_SIGN, COND_ALWAYS, StepPop,  StepPop};
      StepPop:   w = '{ACT_POP,  COND_MORE,   StepPop,  StepLoad};
      StepSpare: w = '{ACT_NONE, COND_ALWAYS, StepLoad, StepLoad};
      default:   w = '{ACT_NONE, COND_ALWAYS, StepLoad, StepLoad};
    endcase
    return w;
  endfunction

  logic [StepWidth-1:0] step;
  logic [StepWidth-1:0] step_next;
  uword_t               uw;
  logic                 hold;
  logic                 taken;

  always_comb begin
    uw = ucode(step);
    unique case (uw.act)
      ACT_LOAD: hold = !stat.in_valid;
      ACT_SIGN: hold = stat.neg && !stat.out_free;
      ACT_POP:  hold = !stat.out_free;
      default:  hold = 1'b0;
    endcase
    unique case (uw.cond)
      COND_HEX:  taken = stat.hex;
      COND_QNZ:  taken = stat.q_nz;
      COND_VNZ:  taken = stat.v_nz;
      COND_MORE: taken = stat.more;
      default:   taken = 1'b1;
    endcase
    if (hold) begin
      step_next = step;
    end else if (taken) begin
      step_next = uw.jmp;
    end else begin
      step_next = uw.nxt;
    end
    ctrl.act = uw.act;
    ctrl.go  = !hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= StepLoad;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- src/i2a_dp.sv -----
module i2a_dp
  import i2a_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  input  logic                  in_valid,
  input  logic [1:0]            op,
  input  logic [ValueWidth-1:0] value,
  input  logic                  out_stall,
  output stat_t                 stat,
  output logic                  out_valid,
  output logic [CharWidth-1:0]  char_code,
  output logic                  last_char,
  output logic [CountWidth-1:0] running_count
);

  function automatic logic [CharWidth-1:0] char_of(input logic [DigitWidth-1:0] d,
                                                   input logic upper);
    logic [CharWidth-1:0] dz;
    dz = {{(CharWidth-DigitWidth){1'b0}}, d};
    if (d < 4'd10) begin
      return 8'h30 + dz;
    end else if (upper) begin
      return 8'h37 + dz;
    end else begin
      return 8'h57 + dz;
    end
  endfunction

  op_t                      mode;
  logic                     neg;
  logic [ValueWidth-1:0]    v;
  logic [QuotWidth-1:0]     q;
  logic [DigitWidth-1:0]    stk [StackDepth];
  logic [StackIdxWidth-1:0] sp;
  logic [CountWidth-1:0]    char_total;

  logic [2*ValueWidth-1:0]  prod;
  logic [DigitWidth-1:0]    rem;
  logic [DigitWidth-1:0]    top;
  logic                     load_neg;
  logic                     out_free;
  logic                     emit;

  always_comb begin
    prod     = {{ValueWidth{1'b0}}, v} * {{ValueWidth{1'b0}}, RecipTen};
    rem      = v[DigitWidth-1:0] - {q[0], 3'b000} - {q[2:0], 1'b0};
    top      = stk[sp - StackIdxWidth'(1)];
    load_neg = (op == OP_SDEC) && value[ValueWidth-1];
    out_free = !out_valid || !out_stall;
    emit     = ctrl.go && ((ctrl.act == ACT_POP) || ((ctrl.act == ACT_SIGN) && neg));

    stat.in_valid = in_valid;
    stat.out_free = out_free;
    stat.neg      = neg;
    stat.hex      = mode[1];
    stat.q_nz     = (q != '0);
    stat.v_nz     = (v[ValueWidth-1:DigitWidth] != '0);
    stat.more     = (sp > StackIdxWidth'(1));
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      unique case (ctrl.act)
        ACT_LOAD: begin
          mode <= op_t'(op);
          neg  <= load_neg;
          v    <= load_neg ? (ValueWidth'(0) - value) : value;
          sp   <= '0;
        end
        ACT_MUL: begin
          q <= prod[2*ValueWidth-1:RecipShift];
        end
        ACT_DEC: begin
          stk[sp] <= rem;
          sp      <= sp + StackIdxWidth'(1);
          v       <= {{(ValueWidth-QuotWidth){1'b0}}, q};
        end
        ACT_HEX: begin
          stk[sp] <= v[DigitWidth-1:0];
          sp      <= sp + StackIdxWidth'(1);
          v       <= v >> DigitWidth;
        end
        ACT_POP: begin
          sp <= sp - StackIdxWidth'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctrl.act == ACT_POP) begin
        char_code <= char_of(top, mode == OP_UHEX);
        last_char <= (sp == StackIdxWidth'(1));
      end else begin
        char_code <= CharMinus;
        last_char <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      char_total <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        if (char_total != '1) begin
          char_total <= char_total + CountWidth'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign running_count = char_total;

endmodule

// ----- src/integer_to_ascii_formatter.sv -----
// Integer to ASCII formatter.
// Input channel (in_valid / in_stall): one request carries op and value.
// op selects signed decimal, unsigned decimal, lowercase hex or uppercase hex.
// Output channel (out_valid / out_stall): one request per character, most
// significant digit first, with last_char on the final character and
// running_count giving the characters delivered since reset, this one included.
// A microcode step counter runs each request: load, digit extraction into a
// small stack, optional minus sign, then one pop per digit.
// Each decimal digit takes a reciprocal multiply step, then a remainder step;
// each hex digit takes a shift step alone. A minus sign, if any, comes out
// before the first digit; the digits then follow one per cycle while the
// output is not stalled.
// A new request is taken only once the previous one's last digit is popped.
// While out_valid and out_stall are both high the output register holds,
// and the sequencer waits at any step that would emit a character.
// in_stall is low only while the sequencer sits in its load step.
// Reset clears the sequencer, the output valid flag and the character count.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [ValueWidth-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CharWidth-1:0]  char_code,
  output logic                  last_char,
  output logic [CountWidth-1:0] running_count
);

  ctrl_t ctrl;
  stat_t stat;

  i2a_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  i2a_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .in_valid      (in_valid),
    .op            (op),
    .value         (value),
    .out_stall     (out_stall),
    .stat          (stat),
    .out_valid     (out_valid),
    .char_code     (char_code),
    .last_char     (last_char),
    .running_count (running_count)
  );

  assign in_stall = (ctrl.act != ACT_LOAD);

endmodule

// ----- src/i2a_chk.sv -----
module i2a_chk
  import i2a_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [1:0]            op,
  input logic [ValueWidth-1:0] value,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CharWidth-1:0]  char_code,
  input logic                  last_char,
  input logic [CountWidth-1:0] running_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char)
      && $stable(running_count))
    else $error("stalled output request changed");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 out_valid |->
      (running_count == $past(running_count) + CountWidth'(1))
      || (($past(running_count) == '1) && (running_count == '1)))
    else $error("running_count did not advance by one");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == CharMinus) |-> !last_char)
    else $error("minus sign flagged as last character");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CharMinus)
      || ((char_code >= 8'h30) && (char_code <= 8'h39))
      || ((char_code >= 8'h41) && (char_code <= 8'h46))
      || ((char_code >= 8'h61) && (char_code <= 8'h66)))
    else $error("illegal character code");

endmodule

bind integer_to_ascii_formatter i2a_chk u_i2a_chk (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import i2a_pkg::*;

  typedef struct {
    logic [CharWidth-1:0]  code;
    logic                  last;
    logic [CountWidth-1:0] cnt;
  } char_t;

  typedef struct {
    op_t                   fmt;
    logic [ValueWidth-1:0] val;
    string                 txt;
  } dir_row_t;

  localparam logic [CharWidth-1:0] CharZero = "0";
  localparam logic [CharWidth-1:0] CharLowA = "a";
  localparam logic [CharWidth-1:0] CharUpA  = "A";
  localparam int RandReqs = 250;
  localparam int HoldAfter = 120;
  localparam int HoldCycles = 200;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            op;
  logic [ValueWidth-1:0] value;
  logic                  out_valid;
  logic                  out_stall;
  logic [CharWidth-1:0]  char_code;
  logic                  last_char;
  logic [CountWidth-1:0] running_count;

  char_t                 pending_chars[$];
  logic [CountWidth-1:0] char_tally = '0;
  int                    reqs_taken = 0;
  bit                    failed = 0;

  dir_row_t dir_rows [0:19] = '{
    '{OP_SDEC, 32'h0000_0000, "0"},
    '{OP_UDEC, 32'h0000_0000, "0"},
    '{OP_LHEX, 32'h0000_0000, "0"},
    '{OP_UHEX, 32'h0000_0000, "0"},
    '{OP_SDEC, 32'h7FFF_FFFF, "2147483647"},
    '{OP_SDEC, 32'h8000_0000, "-2147483648"},
    '{OP_SDEC, 32'hFFFF_FFFF, "-1"},
    '{OP_UDEC, 32'hFFFF_FFFF, "4294967295"},
    '{OP_UDEC, 32'h8000_0000, "2147483648"},
    '{OP_LHEX, 32'hFFFF_FFFF, "ffffffff"},
    '{OP_UHEX, 32'hFFFF_FFFF, "FFFFFFFF"},
    '{OP_LHEX, 32'h8000_0000, "80000000"},
    '{OP_SDEC, 32'h0000_0009, "9"},
    '{OP_UDEC, 32'h0000_000A, "10"},
    '{OP_UDEC, 32'h3B9A_CA00, "1000000000"},
    '{OP_LHEX, 32'hABCD_EF01, ""},
    '{OP_UHEX, 32'h89AB_CDEF, ""},
    '{OP_SDEC, 32'hFFFE_1DC0, ""},
    '{OP_SDEC, 32'hFFFF_FFF6, ""},
    '{OP_UHEX, 32'h0000_0001, "1"}
  };

  integer_to_ascii_formatter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_code     (char_code),
    .last_char     (last_char),
    .running_count (running_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic note_char(logic [CharWidth-1:0] c, logic l);
    if (char_tally != '1) char_tally++;
    pending_chars.push_back('{c, l, char_tally});
  endtask

  task automatic note_text(string s);
    for (int i = 0; i < s.len(); i++) note_char(s[i], i == s.len() - 1);
  endtask

  task automatic format_text(op_t fmt, logic [ValueWidth-1:0] v);
    logic [ValueWidth-1:0] mag;
    logic [CharWidth-1:0]  digs[$];
    logic [3:0]            nib;
    bit                    neg;
    neg = (fmt == OP_SDEC) && v[ValueWidth-1];
    mag = neg ? -v : v;
    if (fmt == OP_SDEC || fmt == OP_UDEC) begin
      do begin
        digs.push_front(CharZero + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
    end else begin
      do begin
        nib = mag[3:0];
        if (nib < 10) digs.push_front(CharZero + 8'(nib));
        else digs.push_front((fmt == OP_LHEX ? CharLowA : CharUpA) + 8'(nib - 10));
        mag = mag >> 4;
      end while (mag != 0);
    end
    if (neg) note_char(CharMinus, 1'b0);
    foreach (digs[i]) note_char(digs[i], i == digs.size() - 1);
  endtask

  function automatic logic [ValueWidth-1:0] rand_value();
    logic [ValueWidth-1:0] tens [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                         10000000, 100000000, 1000000000};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(0, 20);
      5: return tens[$urandom_range(0, 9)] - $urandom_range(0, 1);
      6: return 32'h8000_0000 + $urandom_range(0, 2) - 1;
      7: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      8: return $urandom >> $urandom_range(0, 31);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 20);
    endcase
  endfunction

  // hold the request until it is taken, then record what it should print
  task automatic send_req(op_t fmt, logic [ValueWidth-1:0] v, string txt);
    op       <= fmt;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    reqs_taken++;
    if (txt.len() != 0) note_text(txt);
    else format_text(fmt, v);
  endtask

  task automatic idle_sender();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 4);
    else gap = $urandom_range(15, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int  r;
    bit  held;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      if (!held && reqs_taken >= HoldAfter) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end else if (r < 90) begin
          out_stall <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, got %h last %b count %0d",
                 $time, char_code, last_char, running_count);
        failed = 1;
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code) begin
          $display("%0t: char_code mismatch: expected %h, got %h",
                   $time, want.code, char_code);
          failed = 1;
        end
        if (last_char !== want.last) begin
          $display("%0t: last_char mismatch: expected %b, got %b",
                   $time, want.last, last_char);
          failed = 1;
        end
        if (running_count !== want.cnt) begin
          $display("%0t: running_count mismatch: expected %0d, got %0d",
                   $time, want.cnt, running_count);
          failed = 1;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_SDEC;
    value    = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].fmt, dir_rows[i].val, dir_rows[i].txt);
      idle_sender();
    end
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);

    repeat (RandReqs) begin
      send_req(op_t'($urandom_range(0, 3)), rand_value(), "");
      idle_sender();
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
